[sv/gbc_pkg.sv]
// gbc_pkg: shared types, constants and the round function of the block cipher
// used by gbc_round, gbc_skid and gost_block_cipher_ecb; depends on nothing
`default_nettype none

package gbc_pkg;

  // number of cipher rounds, one pipeline stage each
  localparam int ROUNDS = 32;

  // key register file geometry
  localparam int KEY_WORDS = 8;
  localparam int KEY_IDX_W = 3;
  localparam int WORD_W    = 32;

  // configuration address: byte address of 32-bit registers
  localparam int CFG_ADDR_W = 5;

  // substitution rows, entry n sits at bits [4n+3:4n]; row j serves the nibble
  // at bits [31-4j:28-4j]
  localparam logic [63:0] SBOX_ROW [8] = '{
    64'h35F7C1B6E08D29A4,
    64'h95701832AFD6C4BE,
    64'hB9067CFE243AD185,
    64'h352BC64EF9801AD7,
    64'h2B30E9A48DF517C6,
    64'hEFC95863D1270AB4,
    64'hC2867EA095F314BD,
    64'hC8B6E3294A750DF1
  };

  // input item
  typedef struct packed {
    logic              decrypt;
    logic [WORD_W-1:0] block_high;
    logic [WORD_W-1:0] block_low;
  } gbc_in_t;

  // result item
  typedef struct packed {
    logic [WORD_W-1:0] out_high;
    logic [WORD_W-1:0] out_low;
  } gbc_out_t;

  // payload carried between round stages
  typedef struct packed {
    logic              dec;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } gbc_stage_t;

  // key add, eight nibble substitutions, rotate left by 11
  function automatic logic [WORD_W-1:0] round_f(input logic [WORD_W-1:0] half,
                                               input logic [WORD_W-1:0] kw);
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] sub;
    logic [3:0]        nib;
    sum = half + kw;
    sub = '0;
    for (int j = 0; j < 8; j++) begin
      nib = sum[(7-j)*4 +: 4];
      sub[(7-j)*4 +: 4] = SBOX_ROW[j][{nib, 2'b00} +: 4];
    end
    return {sub[20:0], sub[31:21]};
  endfunction

endpackage

`default_nettype wire

[sv/gbc_round.sv]
// gbc_round: one registered Feistel round of the block cipher
// depends on gbc_pkg (stage type, round function)
`default_nettype none

module gbc_round #(
  parameter int ROUNDS = gbc_pkg::ROUNDS,
  parameter int STAGE  = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        adv,
  input  wire logic                        up_valid,
  input  wire gbc_pkg::gbc_stage_t         up_data,
  input  wire logic [gbc_pkg::WORD_W-1:0]  key_enc,
  input  wire logic [gbc_pkg::WORD_W-1:0]  key_dec,
  output logic                             dn_valid,
  output gbc_pkg::gbc_stage_t              dn_data
);

  localparam bit LAST = (STAGE == ROUNDS - 1);

  logic                          valid_r;
  gbc_pkg::gbc_stage_t           data_r;
  gbc_pkg::gbc_stage_t           data_nxt;
  logic [gbc_pkg::WORD_W-1:0]    t;

  // round: key word follows the item's direction
  always_comb begin
    t = gbc_pkg::round_f(up_data.a, up_data.dec ? key_dec : key_enc) ^ up_data.b;
    data_nxt.dec = up_data.dec;
    if (LAST) begin
      data_nxt.a = up_data.a;
      data_nxt.b = t;
    end else begin
      data_nxt.a = t;
      data_nxt.b = up_data.a;
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= up_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

[sv/gbc_skid.sv]
// gbc_skid: output register with one skid entry behind the round pipeline
// depends on gbc_pkg (result item type)
`default_nettype none

module gbc_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  input  wire gbc_pkg::gbc_out_t up_data,
  output logic                   up_stall,
  output logic                   out_valid,
  output gbc_pkg::gbc_out_t      out_data,
  input  wire logic              out_stall
);

  logic              out_valid_r;
  gbc_pkg::gbc_out_t out_data_r;
  logic              skid_valid_r;
  gbc_pkg::gbc_out_t skid_data_r;
  logic              up_acc;
  logic              out_free;

  assign up_acc   = up_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_r  <= skid_valid_r || up_acc;
        skid_valid_r <= 1'b0;
      end else if (up_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : up_data;
    end
    if (!out_free && up_acc) begin
      skid_data_r <= up_data;
    end
  end

  assign up_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a parked item always has a result ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result at the output");

  // an arriving item meets a stalled result and must be parked
  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && up_valid && !skid_valid_r) |=> skid_valid_r)
    else $error("item lost behind a stalled result");

  // a parked item moves on once the output drains
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_stall) |=> !skid_valid_r)
    else $error("skid entry not released");

endmodule

`default_nettype wire

[sv/gost_block_cipher_ecb.sv]
// gost_block_cipher_ecb: top level, key registers, round pipeline, output stage
// depends on gbc_pkg, gbc_round, gbc_skid
`default_nettype none

// GOST 28147-89 ECB encryptor/decryptor with one fully unrolled round per
// pipeline stage. A block enters every clock while in_stall is low; its result
// passes through 32 round stages then the output register. The direction
// bit travels with each block, so encrypt and decrypt items may be mixed
// freely. When the output is stalled, one extra result is parked in a skid
// entry and then the whole round pipeline holds; in_stall comes straight from
// that skid entry's flag. Key words sit at byte addresses 0x00..0x1C and are
// to be written only while no block is in flight.
module gost_block_cipher_ecb #(
  parameter int ROUNDS = gbc_pkg::ROUNDS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire gbc_pkg::gbc_in_t               in_item,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output gbc_pkg::gbc_out_t                   out_item,
  // key registers
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [gbc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [gbc_pkg::WORD_W-1:0]     pwdata,
  output logic [gbc_pkg::WORD_W-1:0]          prdata,
  output logic                                pready
);

  logic [gbc_pkg::WORD_W-1:0]     key_r [gbc_pkg::KEY_WORDS];
  logic [gbc_pkg::KEY_IDX_W-1:0]  cfg_idx;
  logic                           adv;
  logic [ROUNDS:0]                vld;
  gbc_pkg::gbc_stage_t            stg [ROUNDS+1];
  gbc_pkg::gbc_out_t              last_out;
  logic                           skid_stall;

  // key register file
  assign cfg_idx = paddr[gbc_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = key_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) begin
        key_r[i] <= '0;
      end
    end else if (psel && penable && pwrite && pready) begin
      key_r[cfg_idx] <= pwdata;
    end
  end

  // pipeline advances unless the skid entry is taken
  assign adv      = !skid_stall;
  assign in_stall = skid_stall;

  // entry into the first round
  assign vld[0]     = in_valid;
  assign stg[0].dec = in_item.decrypt;
  assign stg[0].a   = in_item.block_high;
  assign stg[0].b   = in_item.block_low;

  // round stages with fixed key schedule per direction
  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    localparam int KE = (g < ROUNDS - 8) ? (g % 8) : (7 - (g % 8));
    localparam int KD = (g < 8) ? (g % 8) : (7 - (g % 8));
    gbc_round #(
      .ROUNDS (ROUNDS),
      .STAGE  (g)
    ) u_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .up_valid (vld[g]),
      .up_data  (stg[g]),
      .key_enc  (key_r[gbc_pkg::KEY_IDX_W'(KE)]),
      .key_dec  (key_r[gbc_pkg::KEY_IDX_W'(KD)]),
      .dn_valid (vld[g+1]),
      .dn_data  (stg[g+1])
    );
  end

  // result halves
  assign last_out.out_high = stg[ROUNDS].a;
  assign last_out.out_low  = stg[ROUNDS].b;

  gbc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (vld[ROUNDS]),
    .up_data   (last_out),
    .up_stall  (skid_stall),
    .out_valid (out_valid),
    .out_data  (out_item),
    .out_stall (out_stall)
  );

  // a held pipeline keeps every stage's occupancy
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld[ROUNDS:1]))
    else $error("round pipeline moved while held");

endmodule

`default_nettype wire

[bench/testbench.sv]
// testbench: self-checking bench for the gost_block_cipher_ecb block cipher pipeline
// drives blocks through the valid/stall channels and loads keys over the apb port
// depends on gbc_pkg and gost_block_cipher_ecb
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_STRIDE  = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int N_VECTORS   = 21;

  // substitution rows, entry n at nibble n counted from the left
  localparam logic [0:7][63:0] SUBST_ROWS = {
    64'h4A92D80E6B1C7F53,
    64'hEB4C6DFA23810759,
    64'h581DA342EFC7609B,
    64'h7DA1089FE46CB253,
    64'h6C715FD84A9E03B2,
    64'h4BA0721D36859CFE,
    64'hDB413F590AE7682C,
    64'h1FD057A4923E6B8C
  };

  // directed row: when undo is set the block is the previous row's result,
  // and hi/lo hold the block that must come back
  typedef struct packed {
    logic        dec;
    logic [31:0] hi;
    logic [31:0] lo;
    logic        undo;
  } vector_t;

  localparam vector_t [0:N_VECTORS-1] VECTORS = {
    {1'b0, 32'h00000000, 32'h00000000, 1'b0},
    {1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0},
    {1'b1, 32'h00000000, 32'h00000000, 1'b0},
    {1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0},
    {1'b0, 32'h80000000, 32'h00000001, 1'b0},
    {1'b1, 32'h00000001, 32'h80000000, 1'b0},
    {1'b0, 32'hAAAAAAAA, 32'h55555555, 1'b0},
    {1'b0, 32'h55555555, 32'hAAAAAAAA, 1'b0},
    {1'b1, 32'hAAAAAAAA, 32'h55555555, 1'b0},
    {1'b0, 32'h01234567, 32'h89ABCDEF, 1'b0},
    {1'b1, 32'h01234567, 32'h89ABCDEF, 1'b1},
    {1'b1, 32'hFEDCBA98, 32'h76543210, 1'b0},
    {1'b0, 32'hFEDCBA98, 32'h76543210, 1'b1},
    {1'b0, 32'hFFFFFFFF, 32'h00000000, 1'b0},
    {1'b1, 32'hFFFFFFFF, 32'h00000000, 1'b1},
    {1'b1, 32'h00000000, 32'hFFFFFFFF, 1'b0},
    {1'b0, 32'h00000000, 32'hFFFFFFFF, 1'b1},
    {1'b0, 32'h0000000F, 32'hF0000000, 1'b0},
    {1'b1, 32'h7FFFFFFF, 32'h80000000, 1'b0},
    {1'b0, 32'hDEADBEEF, 32'h0BADF00D, 1'b0},
    {1'b1, 32'hDEADBEEF, 32'h0BADF00D, 1'b1}
  };

  typedef enum int {KEY_ONES, KEY_CHECKER, KEY_RANDOM} key_fill_t;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                                clk;
  logic                                rst_n     = 1'b0;
  logic                                in_valid  = 1'b0;
  logic                                in_stall;
  gbc_pkg::gbc_in_t                    in_item   = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  gbc_pkg::gbc_out_t                   out_item;
  logic                                psel      = 1'b0;
  logic                                penable   = 1'b0;
  logic                                pwrite    = 1'b0;
  logic [gbc_pkg::CFG_ADDR_W-1:0]      paddr     = '0;
  logic [gbc_pkg::WORD_W-1:0]          pwdata    = '0;
  logic [gbc_pkg::WORD_W-1:0]          prdata;
  logic                                pready;

  // key copy, result queue, counters
  logic [gbc_pkg::WORD_W-1:0] key_copy [gbc_pkg::KEY_WORDS];
  gbc_pkg::gbc_out_t          ciphertext_q [$];
  gbc_pkg::gbc_out_t          oldest;
  gbc_pkg::gbc_out_t          last_result;
  int                errors       = 0;
  int                items_sent   = 0;
  int                results_seen = 0;
  int                key_loads    = 0;
  int                burst_left   = 0;
  bit                steady       = 1'b0;
  bit                hold_armed   = 1'b0;
  int                hold_left    = 0;
  stall_mode_t       stall_mode   = STALL_NONE;
  int                mode_left    = 0;
  int                tick         = 0;

  gost_block_cipher_ecb u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("** gost_block_cipher_ecb: FAILED **");
    $finish;
  end

  // key add, substitution, rotate left by 11
  function automatic logic [31:0] gost_mix(input logic [31:0] half, input logic [31:0] kw);
    logic [31:0] sum;
    logic [31:0] sub;
    int          nib;
    sum = half + kw;
    sub = '0;
    for (int j = 0; j < 8; j++) begin
      nib = sum[31-4*j -: 4];
      sub[31-4*j -: 4] = SUBST_ROWS[j][63-4*nib -: 4];
    end
    return {sub[20:0], sub[31:21]};
  endfunction

  // 32 feistel rounds with the direction's key order, no swap after the last
  function automatic gbc_pkg::gbc_out_t gost_ecb(input gbc_pkg::gbc_in_t blk);
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       t;
    int                fwd_rounds;
    int                ki;
    gbc_pkg::gbc_out_t res;
    a = blk.block_high;
    b = blk.block_low;
    fwd_rounds = blk.decrypt ? 8 : gbc_pkg::ROUNDS - 8;
    for (int r = 0; r < gbc_pkg::ROUNDS; r++) begin
      ki = (r < fwd_rounds) ? r % 8 : 7 - r % 8;
      t = gost_mix(a, key_copy[ki]) ^ b;
      if (r != gbc_pkg::ROUNDS - 1) begin
        b = a;
        a = t;
      end else begin
        b = t;
      end
    end
    res.out_high = a;
    res.out_low  = b;
    return res;
  endfunction

  // mostly random words, some all-zero, all-one, one-hot and one-cold values
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h00000000;
      1: return 32'hFFFFFFFF;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  // one apb transfer: setup, access, then idle
  task automatic cfg_access(input bit wr, input int idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= gbc_pkg::CFG_ADDR_W'(idx * KEY_STRIDE);
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      key_copy[idx] = data;
    end else if (prdata !== key_copy[idx]) begin
      errors++;
      $display("%0t ns: key_word_%0d read expected %h got %h", $time, idx,
               key_copy[idx], prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // load all eight key words, then read them back
  task automatic load_keys(input key_fill_t fill);
    logic [31:0] v;
    for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) begin
      case (fill)
        KEY_ONES:    v = 32'hFFFFFFFF;
        KEY_CHECKER: v = i[0] ? 32'hAAAAAAAA : 32'h55555555;
        default:     v = $urandom;
      endcase
      cfg_access(1'b1, i, v);
    end
    for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) cfg_access(1'b0, i, '0);
    key_loads++;
  endtask

  // sender bursts and gaps
  task automatic pace();
    int gap;
    if (steady) return;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // offer one item and hold it until accepted
  task automatic offer_block(input gbc_pkg::gbc_in_t blk, input gbc_pkg::gbc_out_t want);
    in_valid <= 1'b1;
    in_item  <= blk;
    do @(posedge clk); while (in_stall);
    ciphertext_q.push_back(want);
    items_sent++;
    pace();
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (ciphertext_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_vectors();
    gbc_pkg::gbc_in_t  blk;
    gbc_pkg::gbc_out_t want;
    vector_t           row;
    for (int i = 0; i < N_VECTORS; i++) begin
      row = VECTORS[i];
      blk.decrypt = row.dec;
      if (row.undo) begin
        blk.block_high = last_result.out_high;
        blk.block_low  = last_result.out_low;
        want.out_high  = row.hi;
        want.out_low   = row.lo;
      end else begin
        blk.block_high = row.hi;
        blk.block_low  = row.lo;
        want = gost_ecb(blk);
      end
      last_result = want;
      offer_block(blk, want);
    end
    drain();
  endtask

  task automatic run_random(input int count, input int pause_at);
    gbc_pkg::gbc_in_t blk;
    for (int i = 0; i < count; i++) begin
      // sender pause until the pipeline has emptied
      if (i == pause_at) drain();
      blk.decrypt    = $urandom_range(0, 1);
      blk.block_high = rand_word();
      blk.block_low  = rand_word();
      offer_block(blk, gost_ecb(blk));
    end
    drain();
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) key_copy[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys read back as zero, directed rows under the zero key
    for (int i = 0; i < gbc_pkg::KEY_WORDS; i++) cfg_access(1'b0, i, '0);
    run_vectors();

    // all-ones key: every key addition with a nonzero half wraps
    load_keys(KEY_ONES);
    run_vectors();

    // long output hold with the sender pushing back to back
    load_keys(KEY_RANDOM);
    steady = 1'b1;
    hold_armed = 1'b1;
    run_random(100, -1);
    steady = 1'b0;

    load_keys(KEY_CHECKER);
    run_random(100, 50);

    load_keys(KEY_RANDOM);
    run_random(100, -1);

    load_keys(KEY_RANDOM);
    run_random(80, 30);

    // final wait for stragglers
    for (int w = 0; w < 20000 && ciphertext_q.size() > 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ciphertext_q.size() > 0) begin
      errors += ciphertext_q.size();
      $display("%0t ns: %0d results never arrived", $time, ciphertext_q.size());
    end

    $display("covered %0d blocks (%0d from the directed rows) under %0d key loads plus reset keys",
             items_sent, 2 * N_VECTORS, key_loads);
    $display("checked %0d results with random stalls, a long output hold and mid-run drains",
             results_seen);
    if (errors == 0) begin
      $display("** gost_block_cipher_ecb: PASSED **");
    end else begin
      $display("** gost_block_cipher_ecb: FAILED **");
    end
    $finish;
  end

  // receiver stall: long hold on request, otherwise a changing pattern
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_left  = HOLD_CYCLES;
      hold_armed = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(40, 300);
      end
      mode_left--;
      tick++;
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        default:      out_stall <= (tick % 8 < 3);
      endcase
    end
  end

  // result check against the oldest expected item
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (ciphertext_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none got %h_%h", $time,
                 out_item.out_high, out_item.out_low);
      end else begin
        oldest = ciphertext_q.pop_front();
        if (out_item.out_high !== oldest.out_high) begin
          errors++;
          $display("%0t ns: out_high expected %h got %h", $time, oldest.out_high,
                   out_item.out_high);
        end
        if (out_item.out_low !== oldest.out_low) begin
          errors++;
          $display("%0t ns: out_low expected %h got %h", $time, oldest.out_low,
                   out_item.out_low);
        end
      end
    end
  end

endmodule
